// ===== rtl/core/mfca_pkg.sv =====
// Shared types and constants for the mixed-form complex adder.
// Holds the pipeline control struct, fixed field widths and the CORDIC angle table.
// No dependencies.
`default_nettype none

package mfca_pkg;

  localparam int IN_W  = 16;
  localparam int OUT_W = 17;
  localparam int ZW    = 33;
  localparam int PROD_W = 33;
  localparam int ANG_W = 17;
  localparam int ATAN_LEN = 24;

  localparam logic signed [PROD_W-1:0] INV_GAIN_Q16 = 33'sd39797;
  localparam logic signed [IN_W-1:0]   QUARTER_TURN = 16'sd16384;
  localparam logic signed [ANG_W-1:0]  HALF_TURN    = 17'sd32768;
  localparam logic signed [IN_W-1:0]   COMP_MAX     = 16'sh7fff;
  localparam logic signed [IN_W-1:0]   COMP_MIN     = 16'sh8000;

  typedef struct packed {
    logic valid;
    logic polar;
  } ctl_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ZW-1:0] val;
    case (idx)
      5'd0:  val = 33'sd536870912;
      5'd1:  val = 33'sd316933406;
      5'd2:  val = 33'sd167458907;
      5'd3:  val = 33'sd85004756;
      5'd4:  val = 33'sd42667331;
      5'd5:  val = 33'sd21354465;
      5'd6:  val = 33'sd10679838;
      5'd7:  val = 33'sd5340245;
      5'd8:  val = 33'sd2670163;
      5'd9:  val = 33'sd1335087;
      5'd10: val = 33'sd667544;
      5'd11: val = 33'sd333772;
      5'd12: val = 33'sd166886;
      5'd13: val = 33'sd83443;
      5'd14: val = 33'sd41722;
      5'd15: val = 33'sd20861;
      5'd16: val = 33'sd10430;
      5'd17: val = 33'sd5215;
      5'd18: val = 33'sd2608;
      5'd19: val = 33'sd1304;
      5'd20: val = 33'sd652;
      5'd21: val = 33'sd326;
      5'd22: val = 33'sd163;
      5'd23: val = 33'sd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mfca_prep.sv =====
// Operand front end: gain multiply, quadrant fold and start vector of one lane.
// Cartesian operands are scaled into the working word so the rotation cells pass them.
// Depends on mfca_pkg.
`default_nettype none

module mfca_prep #(
  parameter int G  = 4,
  parameter int XW = 24
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   valid_i,
  input  wire                                   form_i,
  input  wire logic signed [mfca_pkg::IN_W-1:0] first_i,
  input  wire logic signed [mfca_pkg::IN_W-1:0] second_i,
  output mfca_pkg::ctl_t                        ctl_o,
  output logic signed [XW-1:0]                  x_o,
  output logic signed [XW-1:0]                  y_o,
  output logic signed [mfca_pkg::ZW-1:0]        z_o
);
  import mfca_pkg::*;

  localparam int PW = PROD_W + G + 2;

  logic                        valid1_r;
  logic                        polar1_r;
  logic                        fold1_r;
  logic signed [PROD_W-1:0]    prod1_r;
  logic signed [IN_W-1:0]      first1_r;
  logic signed [IN_W-1:0]      second1_r;
  logic signed [ANG_W-1:0]     ang1_r;

  logic                        fold_nxt;
  logic signed [ANG_W-1:0]     ang_nxt;
  logic signed [ANG_W-1:0]     theta_ext;

  logic signed [PW-1:0]        gain_w;
  logic signed [XW-1:0]        x0_w;
  logic signed [XW-1:0]        x_nxt;
  logic signed [XW-1:0]        y_nxt;
  logic signed [ZW-1:0]        z_nxt;

  ctl_t                        ctl_r;
  logic signed [XW-1:0]        x_r;
  logic signed [XW-1:0]        y_r;
  logic signed [ZW-1:0]        z_r;

  always_comb begin
    theta_ext = ANG_W'(second_i);
    fold_nxt  = (second_i > QUARTER_TURN) || (second_i < -QUARTER_TURN);
    if (!fold_nxt) begin
      ang_nxt = theta_ext;
    end else if (second_i > 16'sd0) begin
      ang_nxt = theta_ext - HALF_TURN;
    end else begin
      ang_nxt = theta_ext + HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else begin
      valid1_r <= valid_i;
    end
    polar1_r  <= form_i;
    fold1_r   <= fold_nxt;
    prod1_r   <= PROD_W'(first_i) * INV_GAIN_Q16;
    first1_r  <= first_i;
    second1_r <= second_i;
    ang1_r    <= ang_nxt;
  end

  always_comb begin
    gain_w = ((PW'(prod1_r) <<< G) + PW'(32768)) >>> 16;
    x0_w   = XW'(gain_w);
    if (polar1_r) begin
      x_nxt = fold1_r ? -x0_w : x0_w;
      y_nxt = '0;
      z_nxt = {ang1_r, 16'b0};
    end else begin
      x_nxt = XW'(first1_r) <<< G;
      y_nxt = XW'(second1_r) <<< G;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= valid1_r;
    end
    ctl_r.polar <= polar1_r;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    z_r         <= z_nxt;
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

`default_nettype wire

// ===== rtl/core/mfca_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation by atan(2^-IDX), registered.
// Cartesian items pass through unchanged.
// Depends on mfca_pkg.
`default_nettype none

module mfca_cell #(
  parameter int IDX = 0,
  parameter int XW  = 24
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire mfca_pkg::ctl_t                  ctl_i,
  input  wire logic signed [XW-1:0]            x_i,
  input  wire logic signed [XW-1:0]            y_i,
  input  wire logic signed [mfca_pkg::ZW-1:0]  z_i,
  output mfca_pkg::ctl_t                       ctl_o,
  output logic signed [XW-1:0]                 x_o,
  output logic signed [XW-1:0]                 y_o,
  output logic signed [mfca_pkg::ZW-1:0]       z_o
);
  import mfca_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = atan_entry(5'(IDX));

  ctl_t                  ctl_r;
  logic signed [XW-1:0]  x_r;
  logic signed [XW-1:0]  y_r;
  logic signed [ZW-1:0]  z_r;
  logic signed [XW-1:0]  x_nxt;
  logic signed [XW-1:0]  y_nxt;
  logic signed [ZW-1:0]  z_nxt;
  logic signed [XW-1:0]  xs_w;
  logic signed [XW-1:0]  ys_w;

  always_comb begin
    xs_w = x_i >>> IDX;
    ys_w = y_i >>> IDX;
    if (!ctl_i.polar) begin
      x_nxt = x_i;
      y_nxt = y_i;
      z_nxt = z_i;
    end else if (!z_i[ZW-1]) begin
      x_nxt = x_i - ys_w;
      y_nxt = y_i + xs_w;
      z_nxt = z_i - ANGLE;
    end else begin
      x_nxt = x_i + ys_w;
      y_nxt = y_i - xs_w;
      z_nxt = z_i + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
    ctl_r.polar <= ctl_i.polar;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    z_r         <= z_nxt;
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

`default_nettype wire

// ===== rtl/core/mfca_post.sv =====
// Back end: rounds and saturates both lanes to Q3.12, then forms the Q4.12 sum.
// Two register stages.
// Depends on mfca_pkg.
`default_nettype none

module mfca_post #(
  parameter int G  = 4,
  parameter int XW = 24
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   valid_i,
  input  wire logic signed [XW-1:0]             ax_i,
  input  wire logic signed [XW-1:0]             ay_i,
  input  wire logic signed [XW-1:0]             bx_i,
  input  wire logic signed [XW-1:0]             by_i,
  output logic                                  valid_o,
  output logic signed [mfca_pkg::OUT_W-1:0]     real_o,
  output logic signed [mfca_pkg::OUT_W-1:0]     imag_o
);
  import mfca_pkg::*;

  localparam logic signed [XW-1:0] HALF = (XW'(1) <<< G) >>> 1;

  function automatic logic signed [IN_W-1:0] round_sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    logic signed [IN_W-1:0] s;
    r = (v + HALF) >>> G;
    if (r > XW'(COMP_MAX)) begin
      s = COMP_MAX;
    end else if (r < XW'(COMP_MIN)) begin
      s = COMP_MIN;
    end else begin
      s = IN_W'(r);
    end
    return s;
  endfunction

  logic                    valid1_r;
  logic signed [IN_W-1:0]  ar_r;
  logic signed [IN_W-1:0]  ai_r;
  logic signed [IN_W-1:0]  br_r;
  logic signed [IN_W-1:0]  bi_r;
  logic                    valid_r;
  logic signed [OUT_W-1:0] real_r;
  logic signed [OUT_W-1:0] imag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      valid1_r <= valid_i;
      valid_r  <= valid1_r;
    end
    ar_r   <= round_sat(ax_i);
    ai_r   <= round_sat(ay_i);
    br_r   <= round_sat(bx_i);
    bi_r   <= round_sat(by_i);
    real_r <= OUT_W'(ar_r) + OUT_W'(br_r);
    imag_r <= OUT_W'(ai_r) + OUT_W'(bi_r);
  end

  assign valid_o = valid_r;
  assign real_o  = real_r;
  assign imag_o  = imag_r;

endmodule

`default_nettype wire

// ===== rtl/core/mixed_form_complex_adder.sv =====
// Top level of the mixed-form complex adder: two CORDIC lanes and the summing back end.
// Depends on mfca_pkg, mfca_prep, mfca_cell and mfca_post.
//
// Usage:
//   An item is taken at each rising edge where start is high and busy is low.
//   busy is always low, so one item can be taken in every cycle.
//   Each operand is cartesian (form 0) or polar (form 1, magnitude and binary angle).
//   Polar operands are rotated by a chain of ROTATION_STAGES CORDIC cells, one
//   micro-rotation per cell; cartesian operands ride the same chain unchanged.
//   The result appears on out_sum_real and out_sum_imag for exactly one cycle,
//   marked by out_valid, once the item has passed the registers for the gain
//   multiply and start vector, one register per cell, and the registers for
//   rounding and the final add.
//   Throughput is one item per cycle; items leave in the order they came in.
//   The receiver has no way to hold results off, and none is needed.
//   WORD_BITS sets the working precision: the x and y words carry WORD_BITS - 12
//   guard bits below Q3.12.
//   Synchronous reset drops every item in flight; no result follows from them.
`default_nettype none

module mixed_form_complex_adder #(
  parameter int ROTATION_STAGES = 16,
  parameter int WORD_BITS       = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  output logic                                 busy,
  input  wire                                  in_a_form,
  input  wire logic signed [mfca_pkg::IN_W-1:0] in_a_first,
  input  wire logic signed [mfca_pkg::IN_W-1:0] in_a_second,
  input  wire                                  in_b_form,
  input  wire logic signed [mfca_pkg::IN_W-1:0] in_b_first,
  input  wire logic signed [mfca_pkg::IN_W-1:0] in_b_second,
  output logic                                 out_valid,
  output logic signed [mfca_pkg::OUT_W-1:0]    out_sum_real,
  output logic signed [mfca_pkg::OUT_W-1:0]    out_sum_imag
);
  import mfca_pkg::*;

  localparam int G       = WORD_BITS - 12;
  localparam int XW      = WORD_BITS + 8;
  localparam int LATENCY = ROTATION_STAGES + 4;

  logic accept;

  ctl_t                 a_ctl [0:ROTATION_STAGES];
  logic signed [XW-1:0] a_x   [0:ROTATION_STAGES];
  logic signed [XW-1:0] a_y   [0:ROTATION_STAGES];
  logic signed [ZW-1:0] a_z   [0:ROTATION_STAGES];
  ctl_t                 b_ctl [0:ROTATION_STAGES];
  logic signed [XW-1:0] b_x   [0:ROTATION_STAGES];
  logic signed [XW-1:0] b_y   [0:ROTATION_STAGES];
  logic signed [ZW-1:0] b_z   [0:ROTATION_STAGES];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  mfca_prep #(.G(G), .XW(XW)) u_prep_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (accept),
    .form_i   (in_a_form),
    .first_i  (in_a_first),
    .second_i (in_a_second),
    .ctl_o    (a_ctl[0]),
    .x_o      (a_x[0]),
    .y_o      (a_y[0]),
    .z_o      (a_z[0])
  );

  mfca_prep #(.G(G), .XW(XW)) u_prep_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (accept),
    .form_i   (in_b_form),
    .first_i  (in_b_first),
    .second_i (in_b_second),
    .ctl_o    (b_ctl[0]),
    .x_o      (b_x[0]),
    .y_o      (b_y[0]),
    .z_o      (b_z[0])
  );

  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
    mfca_cell #(.IDX(i), .XW(XW)) u_cell_a (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (a_ctl[i]),
      .x_i   (a_x[i]),
      .y_i   (a_y[i]),
      .z_i   (a_z[i]),
      .ctl_o (a_ctl[i+1]),
      .x_o   (a_x[i+1]),
      .y_o   (a_y[i+1]),
      .z_o   (a_z[i+1])
    );
    mfca_cell #(.IDX(i), .XW(XW)) u_cell_b (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (b_ctl[i]),
      .x_i   (b_x[i]),
      .y_i   (b_y[i]),
      .z_i   (b_z[i]),
      .ctl_o (b_ctl[i+1]),
      .x_o   (b_x[i+1]),
      .y_o   (b_y[i+1]),
      .z_o   (b_z[i+1])
    );
  end

  mfca_post #(.G(G), .XW(XW)) u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (a_ctl[ROTATION_STAGES].valid),
    .ax_i    (a_x[ROTATION_STAGES]),
    .ay_i    (a_y[ROTATION_STAGES]),
    .bx_i    (b_x[ROTATION_STAGES]),
    .by_i    (b_y[ROTATION_STAGES]),
    .valid_o (out_valid),
    .real_o  (out_sum_real),
    .imag_o  (out_sum_imag)
  );

  // Every accepted item yields a result once it has passed the prep stages, every cell and the back end.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("accepted item produced no result at the expected cycle");

  // No result appears without a matching accepted item earlier in the pipeline.
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result strobe without a matching accepted item");

  // Both lanes carry the same item at the end of the rotation chain.
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    a_ctl[ROTATION_STAGES].valid == b_ctl[ROTATION_STAGES].valid)
    else $error("operand lanes out of step");

endmodule

`default_nettype wire
